### design/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg
// Shared widths, opcode codes and the pipeline stage word of the executor.
// ----------------------------------------------------------------------------
package rie_pkg;

    localparam int DATA_W    = 32;
    localparam int PC_W      = 11;
    localparam int REG_AW    = 5;
    localparam int REG_COUNT = 32;
    localparam int MEM_WORDS = 2048;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_MOVI = 4'd3,
        OP_JEQ  = 4'd4,
        OP_AND  = 4'd5,
        OP_XORI = 4'd6,
        OP_JMP  = 4'd7,
        OP_LSL  = 4'd8,
        OP_LSR  = 4'd9,
        OP_MOVR = 4'd10,
        OP_MOVM = 4'd11
    } op_t;

    // what one word carries down the pipe after execute
    typedef struct packed {
        logic              wr;
        logic              load;
        logic              store;
        logic              nop;
        logic [REG_AW-1:0] dest;
        logic [DATA_W-1:0] val;
        logic [PC_W-1:0]   npc;
    } stage_t;

endpackage

### design/risc_instruction_executor.sv
// ----------------------------------------------------------------------------
// risc_instruction_executor
// Executes one instruction word per cycle when nothing stalls it, against a
// register file and data memory, both synchronous RAMs, and reports each outcome.
// ----------------------------------------------------------------------------
// Stages: execute, two address-reduction stages (A, M), memory/writeback
//   (W) and an output register.
// Throughput: one word per cycle unless result_ready stalls; a word reading the
//   destination of a load up to two words ahead waits on the load-use interlock.
// Reset: control cleared at once; then a pass clears the data memory with
//   instruction_ready low. Registers read as zero via valid bits.
module risc_instruction_executor #(
    parameter int MEM_WORDS = rie_pkg::MEM_WORDS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        instruction_valid,
    output logic                        instruction_ready,
    input  logic [31:0]                 instruction,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [rie_pkg::PC_W-1:0]    next_pc,
    output logic                        reg_write,
    output logic [rie_pkg::REG_AW-1:0]  write_reg,
    output logic signed [31:0]          write_data,
    output logic                        mem_store,
    output logic [rie_pkg::PC_W-1:0]    mem_address,
    output logic                        no_operation
);

    localparam int MAW = $clog2(MEM_WORDS);

    // ---- handshake and pipeline control ----
    logic in_fire;
    logic adv;       // stages behind execute move together
    logic hazard;    // load-use interlock on execute
    logic x_move;
    logic w_fire;

    // ---- execute stage ----
    logic                         x_valid_reg;
    logic [31:0]                  x_ins_reg;
    logic [rie_pkg::PC_W-1:0]     pc_reg;
    rie_pkg::op_t                 x_op;
    logic [rie_pkg::REG_AW-1:0]   x_r1;
    logic [rie_pkg::REG_AW-1:0]   x_r2;
    logic [rie_pkg::REG_AW-1:0]   x_srcb;
    logic [31:0]                  x_imm;
    logic [11:0]                  x_shamt;
    logic [31:0]                  opa;
    logic [31:0]                  opb;
    logic [31:0]                  x_sum;
    logic [rie_pkg::PC_W-1:0]     x_pc_inc;
    rie_pkg::stage_t              x_st;

    // ---- register file read side ----
    logic [31:0]                  rd_ins;
    rie_pkg::op_t                 rd_op;
    logic [rie_pkg::REG_AW-1:0]   rd_srcb;
    logic [31:0]                  rf_a_rdata;
    logic [31:0]                  rf_b_rdata;
    logic [rie_pkg::REG_COUNT-1:0] rf_valid_reg;
    logic                         rf_we;
    logic                         lw_valid_reg;
    logic [rie_pkg::REG_AW-1:0]   lw_dest_reg;
    logic [31:0]                  lw_val_reg;

    // ---- address, memory and writeback stages ----
    logic                         a_valid_reg;
    logic                         m_valid_reg;
    logic                         w_valid_reg;
    rie_pkg::stage_t              a_reg;
    rie_pkg::stage_t              m_reg;
    rie_pkg::stage_t              w_reg;
    logic [MAW-1:0]               mod_addr;
    logic [MAW-1:0]               w_maddr_reg;
    logic [31:0]                  w_value;

    // ---- data memory ----
    logic                         clr_busy_reg;
    logic [MAW-1:0]               clr_addr_reg;
    logic                         dm_we;
    logic [MAW-1:0]               dm_waddr;
    logic [31:0]                  dm_wdata;
    logic [31:0]                  dm_rdata;

    // ---- output register ----
    logic                         out_valid_reg;
    logic [rie_pkg::PC_W-1:0]     res_npc_reg;
    logic                         res_wr_reg;
    logic [rie_pkg::REG_AW-1:0]   res_dest_reg;
    logic [31:0]                  res_val_reg;
    logic                         res_store_reg;
    logic [rie_pkg::PC_W-1:0]     res_maddr_reg;
    logic                         res_nop_reg;

    // Newest value of a register as execute must see it: younger stages
    // first, then the write that coincided with the RAM read, then the RAM.
    // A load in A or M never supplies a value; the interlock covers it.
    function automatic logic [31:0] fwd(input logic [rie_pkg::REG_AW-1:0] idx,
                                        input logic [31:0] ram_data);
        logic [31:0] v;
        if (a_valid_reg && a_reg.wr && !a_reg.load && a_reg.dest == idx)
            v = a_reg.val;
        else if (m_valid_reg && m_reg.wr && !m_reg.load && m_reg.dest == idx)
            v = m_reg.val;
        else if (w_valid_reg && w_reg.wr && w_reg.dest == idx)
            v = w_value;
        else if (lw_valid_reg && lw_dest_reg == idx)
            v = lw_val_reg;
        else if (rf_valid_reg[idx])
            v = ram_data;
        else
            v = '0;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign adv     = !out_valid_reg || result_ready;
    assign x_move  = x_valid_reg && adv && !hazard;
    assign in_fire = instruction_valid && instruction_ready;
    assign w_fire  = w_valid_reg && adv;

    assign instruction_ready = !clr_busy_reg && (!x_valid_reg || x_move);

    // ------------------------------------------------------------------
    // Register file: two copies written alike, one read port each.
    // Port A reads r2; port B reads r1 for JEQ/MOVM, else r3. A held word
    // re-reads every cycle so the RAM keeps up with writes behind it.
    // ------------------------------------------------------------------
    assign rd_ins  = in_fire ? instruction : x_ins_reg;
    assign rd_op   = rie_pkg::op_t'(rd_ins[31:28]);
    assign rd_srcb = (rd_op inside {rie_pkg::OP_JEQ, rie_pkg::OP_MOVM}) ?
                     rd_ins[27:23] : rd_ins[17:13];

    assign rf_we = w_fire && w_reg.wr;

    rie_ram #(
        .WIDTH (rie_pkg::DATA_W),
        .DEPTH (rie_pkg::REG_COUNT)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (w_reg.dest),
        .wdata (w_value),
        .re    (1'b1),
        .raddr (rd_ins[22:18]),
        .rdata (rf_a_rdata)
    );

    rie_ram #(
        .WIDTH (rie_pkg::DATA_W),
        .DEPTH (rie_pkg::REG_COUNT)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (w_reg.dest),
        .wdata (w_value),
        .re    (1'b1),
        .raddr (rd_srcb),
        .rdata (rf_b_rdata)
    );

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    assign x_op     = rie_pkg::op_t'(x_ins_reg[31:28]);
    assign x_r1     = x_ins_reg[27:23];
    assign x_r2     = x_ins_reg[22:18];
    assign x_srcb   = (x_op inside {rie_pkg::OP_JEQ, rie_pkg::OP_MOVM}) ?
                      x_r1 : x_ins_reg[17:13];
    assign x_imm    = {{14{x_ins_reg[17]}}, x_ins_reg[17:0]};
    assign x_shamt  = x_ins_reg[11:0];
    assign x_pc_inc = pc_reg + 1'b1;

    // operand select also follows the stage registers the function reads
    always_comb
    begin
        opa = fwd(x_r2, rf_a_rdata);
        opb = fwd(x_srcb, rf_b_rdata);
    end

    assign x_sum = opa + x_imm;

    always_comb
    begin
        x_st       = '0;
        x_st.dest  = x_r1;
        x_st.npc   = x_pc_inc;
        case (x_op)
            rie_pkg::OP_ADD:
            begin
                x_st.wr  = 1'b1;
                x_st.val = opa + opb;
            end
            rie_pkg::OP_SUB:
            begin
                x_st.wr  = 1'b1;
                x_st.val = opa - opb;
            end
            rie_pkg::OP_MUL:
            begin
                x_st.wr  = 1'b1;
                x_st.val = 32'(opa * opb);
            end
            rie_pkg::OP_MOVI:
            begin
                x_st.wr  = 1'b1;
                x_st.val = x_imm;
            end
            rie_pkg::OP_JEQ:
            begin
                if (opb == opa)
                begin
                    x_st.npc = x_pc_inc + x_imm[rie_pkg::PC_W-1:0];
                end
            end
            rie_pkg::OP_AND:
            begin
                x_st.wr  = 1'b1;
                x_st.val = opa & opb;
            end
            rie_pkg::OP_XORI:
            begin
                x_st.wr  = 1'b1;
                x_st.val = opa ^ x_imm;
            end
            rie_pkg::OP_JMP:
            begin
                x_st.npc = x_ins_reg[rie_pkg::PC_W-1:0];
            end
            rie_pkg::OP_LSL:
            begin
                x_st.wr  = 1'b1;
                x_st.val = (x_shamt[11:5] != '0) ? '0 : opa << x_shamt[4:0];
            end
            rie_pkg::OP_LSR:
            begin
                x_st.wr  = 1'b1;
                x_st.val = (x_shamt[11:5] != '0) ? '0 : opa >> x_shamt[4:0];
            end
            rie_pkg::OP_MOVR:
            begin
                x_st.wr   = 1'b1;
                x_st.load = 1'b1;
            end
            rie_pkg::OP_MOVM:
            begin
                x_st.store = 1'b1;
                x_st.val   = opb;   // store data rides in the value field
            end
            default:
            begin
                x_st.nop = 1'b1;
            end
        endcase
        // r0 is hard-wired
        if (x_r1 == '0)
        begin
            x_st.wr = 1'b0;
        end
    end

    // load data appears only in W; anything reading it earlier waits
    always_comb
    begin
        hazard = x_valid_reg &&
                 ((a_valid_reg && a_reg.load && a_reg.wr &&
                   (a_reg.dest == x_r2 || a_reg.dest == x_srcb)) ||
                  (m_valid_reg && m_reg.load && m_reg.wr &&
                   (m_reg.dest == x_r2 || m_reg.dest == x_srcb)));
    end

    // ------------------------------------------------------------------
    // Address reduction (A and M) and data memory
    // ------------------------------------------------------------------
    rie_addr_mod #(
        .MEM_WORDS (MEM_WORDS)
    ) u_addr_mod (
        .clk  (clk),
        .en   (adv),
        .sum  (x_sum),
        .addr (mod_addr)
    );

    // clearing pass owns the write port after reset; pipe is empty then
    assign dm_we    = clr_busy_reg || (adv && m_valid_reg && m_reg.store);
    assign dm_waddr = clr_busy_reg ? clr_addr_reg : mod_addr;
    assign dm_wdata = clr_busy_reg ? '0 : m_reg.val;

    rie_ram #(
        .WIDTH (rie_pkg::DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (adv),
        .raddr (mod_addr),
        .rdata (dm_rdata)
    );

    assign w_value = w_reg.load ? dm_rdata : w_reg.val;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            w_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            rf_valid_reg  <= '0;
            lw_valid_reg  <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                x_valid_reg <= 1'b1;
            end
            else if (x_move)
            begin
                x_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                a_valid_reg <= x_move;
                m_valid_reg <= a_valid_reg;
                w_valid_reg <= m_valid_reg;
            end

            out_valid_reg <= w_fire || (out_valid_reg && !result_ready);

            if (x_move)
            begin
                pc_reg <= x_st.npc;
            end

            if (rf_we)
            begin
                rf_valid_reg[w_reg.dest] <= 1'b1;
                lw_valid_reg             <= 1'b1;
            end

            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == MAW'(MEM_WORDS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_ins_reg <= instruction;
        end

        if (adv)
        begin
            a_reg       <= x_st;
            m_reg       <= a_reg;
            w_reg       <= m_reg;
            w_maddr_reg <= mod_addr;
        end

        if (rf_we)
        begin
            lw_dest_reg <= w_reg.dest;
            lw_val_reg  <= w_value;
        end

        if (w_fire)
        begin
            res_npc_reg   <= w_reg.npc;
            res_wr_reg    <= w_reg.wr;
            res_dest_reg  <= w_reg.wr ? w_reg.dest : '0;
            res_val_reg   <= w_reg.wr ? w_value : '0;
            res_store_reg <= w_reg.store;
            res_maddr_reg <= (w_reg.load || w_reg.store) ?
                             rie_pkg::PC_W'(w_maddr_reg) : '0;
            res_nop_reg   <= w_reg.nop;
        end
    end

    assign result_valid = out_valid_reg;
    assign next_pc      = res_npc_reg;
    assign reg_write    = res_wr_reg;
    assign write_reg    = res_dest_reg;
    assign write_data   = res_val_reg;
    assign mem_store    = res_store_reg;
    assign mem_address  = res_maddr_reg;
    assign no_operation = res_nop_reg;

endmodule

### design/rie_ram.sv
// ----------------------------------------------------------------------------
// rie_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/rie_addr_mod.sv
// ----------------------------------------------------------------------------
// rie_addr_mod
// Two-stage reduction of a 32-bit address modulo MEM_WORDS by reciprocal
// multiplication; output is combinational from the second-stage registers.
// ----------------------------------------------------------------------------
module rie_addr_mod #(
    parameter int MEM_WORDS = rie_pkg::MEM_WORDS,
    localparam int AW       = $clog2(MEM_WORDS)
) (
    input  logic          clk,
    input  logic          en,
    input  logic [31:0]   sum,
    output logic [AW-1:0] addr
);

    // floor(2^32 / N): quotient estimate is q or q-1
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MEM_WORDS);
    localparam logic [AW:0] N_C   = (AW + 1)'(MEM_WORDS);

    logic [31:0] s1_sum_reg;
    logic [31:0] s2_sum_reg;
    logic [31:0] s2_quo_reg;
    logic [64:0] prod;
    logic [AW:0] qn;
    logic [AW:0] rem;
    logic [AW:0] rem_fix;

    assign prod = 65'(s1_sum_reg) * 65'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sum_reg <= sum;
            s2_sum_reg <= s1_sum_reg;
            s2_quo_reg <= prod[63:32];
        end
    end

    // only the low bits matter: remainder is below 2N
    always_comb
    begin
        qn      = s2_quo_reg[AW:0] * N_C;
        rem     = s2_sum_reg[AW:0] - qn;
        rem_fix = (rem >= N_C) ? rem - N_C : rem;
        addr    = rem_fix[AW-1:0];
    end

endmodule

### design/rie_checker.sv
// ----------------------------------------------------------------------------
// rie_checker
// Port-level checks on the executor's result words and intake, bound to the top level.
// ----------------------------------------------------------------------------
module rie_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        instruction_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [rie_pkg::PC_W-1:0]    next_pc,
    input logic                        reg_write,
    input logic [rie_pkg::REG_AW-1:0]  write_reg,
    input logic signed [31:0]          write_data,
    input logic                        mem_store,
    input logic [rie_pkg::PC_W-1:0]    mem_address,
    input logic                        no_operation
);

    // stalled word stays valid and holds next_pc, reg_write, write_data, mem_address
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(next_pc) && $stable(reg_write) &&
            $stable(write_data) && $stable(mem_address))
        else $error("result word changed while stalled");

    // r0 never reported; no value without a write
    a_wr_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (reg_write == (write_reg != '0)) &&
                         (reg_write || write_data == '0))
        else $error("register write fields inconsistent");

    // unassigned opcodes touch no register, memory or address; stores touch no register
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(reg_write && mem_store) &&
            !(no_operation && (reg_write || mem_store || mem_address != '0)))
        else $error("conflicting effects in one word");

    // memory clearing blocks intake straight after reset
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !instruction_ready && !result_valid)
        else $error("intake open during memory clearing");

endmodule

bind risc_instruction_executor rie_checker u_rie_checker (.*);
